>>> src/thc_pkg.sv
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types and constants of the temperature and humidity compensation.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int TEMP_STAGES = 3;
    localparam int HUM_STAGES  = 8;
    localparam int LATENCY     = TEMP_STAGES + HUM_STAGES;

    localparam logic signed [31:0] FINE_OFFSET = 32'sd76800;
    localparam logic signed [31:0] HUM_CLAMP   = 32'sd419430400;
    localparam logic signed [31:0] HUM_ROUND_A = 32'sd16384;
    localparam logic signed [31:0] HUM_BIAS_B  = 32'sd2097152;
    localparam logic signed [31:0] HUM_ROUND_B = 32'sd8192;
    localparam logic signed [31:0] HUM_BIAS_E  = 32'sd32768;
    localparam logic signed [31:0] TEMP_ROUND  = 32'sd128;

    localparam logic [2:0] CFG_TEMP_REF         = 3'd0;
    localparam logic [2:0] CFG_TEMP_SLOPE       = 3'd1;
    localparam logic [2:0] CFG_TEMP_CURVE       = 3'd2;
    localparam logic [2:0] CFG_HUM_QUAD         = 3'd3;
    localparam logic [2:0] CFG_HUM_GAIN         = 3'd4;
    localparam logic [2:0] CFG_HUM_TEMP_LIN     = 3'd5;
    localparam logic [2:0] CFG_HUM_OFFSET_SLOPE = 3'd6;
    localparam logic [2:0] CFG_HUM_TEMP_SQ      = 3'd7;

    typedef struct packed {
        logic        [15:0] temp_ref;
        logic signed [15:0] temp_slope;
        logic signed [15:0] temp_curve;
        logic        [7:0]  hum_quad;
        logic signed [15:0] hum_gain;
        logic        [7:0]  hum_temp_lin;
        logic signed [11:0] hum_offset;
        logic signed [11:0] hum_slope;
        logic signed [7:0]  hum_temp_sq;
    } t_coef;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] fine;
        logic signed [31:0] x;
        logic        [15:0] hum_adc;
    } t_fine;

endpackage

>>> src/thc_fine_temp.sv
// ----------------------------------------------------------------------------
// thc_fine_temp
// Three-stage pipeline forming the fine temperature from the raw conversion.
// ----------------------------------------------------------------------------
module thc_fine_temp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  thc_pkg::t_coef i_coef,
    input  logic           i_valid,
    input  logic [19:0]    i_temp_adc,
    input  logic [15:0]    i_hum_adc,
    output thc_pkg::t_fine o_fine
);
    import thc_pkg::*;

    logic signed [31:0] t2, t3, lin, d;
    logic signed [31:0] n_fine;

    logic               r_v1, r_v2, r_v3;
    logic signed [31:0] r_p1, r_dd, r_lin, r_q, r_fine, r_x;
    logic        [15:0] r_h1, r_h2, r_h3;

    assign t2  = {{16{i_coef.temp_slope[15]}}, i_coef.temp_slope};
    assign t3  = {{16{i_coef.temp_curve[15]}}, i_coef.temp_curve};
    assign lin = {15'b0, i_temp_adc[19:3]} - {15'b0, i_coef.temp_ref, 1'b0};
    assign d   = {16'b0, i_temp_adc[19:4]} - {16'b0, i_coef.temp_ref};

    assign n_fine = r_lin + (r_q >>> 14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= lin * t2;
        r_dd   <= d * d;
        r_h1   <= i_hum_adc;
        r_lin  <= r_p1 >>> 11;
        r_q    <= (r_dd >>> 12) * t3;
        r_h2   <= r_h1;
        r_fine <= n_fine;
        r_x    <= n_fine - FINE_OFFSET;
        r_h3   <= r_h2;
    end

    assign o_fine.valid   = r_v3;
    assign o_fine.fine    = r_fine;
    assign o_fine.x       = r_x;
    assign o_fine.hum_adc = r_h3;

endmodule

>>> src/thc_humidity.sv
// ----------------------------------------------------------------------------
// thc_humidity
// Eight-stage pipeline for the output temperature and the humidity polynomial.
// ----------------------------------------------------------------------------
module thc_humidity (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  thc_pkg::t_coef     i_coef,
    input  thc_pkg::t_fine     i_fine,
    output logic               o_valid,
    output logic signed [23:0] o_temperature,
    output logic        [16:0] o_humidity
);
    import thc_pkg::*;

    localparam int NS = HUM_STAGES;

    logic signed [31:0] h2, h5, h6, htl, hq;
    logic signed [31:0] t5, n_a, n_b1, n_b, n_s, n_x3;
    logic        [16:0] n_hum;

    logic [NS-1:0]      r_v;
    logic signed [23:0] r_temp [NS];
    logic signed [31:0] r_m1, r_m2, r_m3, r_a5, r_e1, r_e2;
    logic signed [31:0] r_b0, r_a6, r_b2, r_a7, r_x8, r_ss, r_x9, r_pc, r_x10;
    logic        [15:0] r_h4;
    logic        [16:0] r_hum;

    assign h2  = {{16{i_coef.hum_gain[15]}}, i_coef.hum_gain};
    assign h5  = {{20{i_coef.hum_slope[11]}}, i_coef.hum_slope};
    assign h6  = {{24{i_coef.hum_temp_sq[7]}}, i_coef.hum_temp_sq};
    assign htl = {24'b0, i_coef.hum_temp_lin};
    assign hq  = {24'b0, i_coef.hum_quad};

    assign t5   = (i_fine.fine <<< 2) + i_fine.fine + TEMP_ROUND;
    assign n_a  = $signed({2'b0, r_h4, 14'b0} - {i_coef.hum_offset, 20'b0} - r_m3
                          + HUM_ROUND_A) >>> 15;
    assign n_b1 = (r_b0 >>> 10) + HUM_BIAS_B;
    assign n_b  = (r_b2 + HUM_ROUND_B) >>> 14;
    assign n_s  = r_x8 >>> 15;
    assign n_x3 = r_x10 - (r_pc >>> 4);

    always_comb begin
        if (n_x3[31]) begin
            n_hum = '0;
        end else if (n_x3 > HUM_CLAMP) begin
            n_hum = HUM_CLAMP[28:12];
        end else begin
            n_hum = n_x3[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NS-2:0], i_fine.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp[0] <= t5[31:8];
        for (int i = 1; i < NS; i++) begin
            r_temp[i] <= r_temp[i-1];
        end
        // polynomial terms in x
        r_m1  <= i_fine.x * h6;
        r_m2  <= i_fine.x * htl;
        r_m3  <= h5 * i_fine.x;
        r_h4  <= i_fine.hum_adc;
        r_a5  <= n_a;
        r_e1  <= r_m1 >>> 10;
        r_e2  <= (r_m2 >>> 11) + HUM_BIAS_E;
        r_b0  <= r_e1 * r_e2;
        r_a6  <= r_a5;
        r_b2  <= n_b1 * h2;
        r_a7  <= r_a6;
        r_x8  <= r_a7 * n_b;
        // self-square correction
        r_ss  <= n_s * n_s;
        r_x9  <= r_x8;
        r_pc  <= (r_ss >>> 7) * hq;
        r_x10 <= r_x9;
        r_hum <= n_hum;
    end

    assign o_valid       = r_v[NS-1];
    assign o_temperature = r_temp[NS-1];
    assign o_humidity    = r_hum;

endmodule

>>> src/temp_humidity_compensation.sv
// ----------------------------------------------------------------------------
// temp_humidity_compensation
// Temperature and humidity compensation on 32-bit wrapping integer arithmetic.
// ----------------------------------------------------------------------------
// Input channel: a sample (i_temp_adc, i_hum_adc) transfers at a rising edge
// with start high and busy low. busy is always low, so one sample can be
// given in every cycle.
// Output channel: o_done is high for one cycle with o_temperature (0.01 degC)
// and o_humidity (Q.10 percent, 0..102400). The receiver cannot stall; results
// leave in input order.
// Pipeline: an eleven-stage multiplier chain (three stages for the fine
// temperature, eight for the humidity polynomial) lies between the start
// edge and the o_done cycle. Throughput: one sample per cycle.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
// edge; change coefficients only while no sample is in flight.
// Reset: synchronous, active low; clears the coefficients and the pipeline
// valid bits, so no result appears from a sample taken before reset.
// ----------------------------------------------------------------------------
module temp_humidity_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        i_temp_adc,
    input  logic [15:0]        i_hum_adc,
    output logic               o_done,
    output logic signed [23:0] o_temperature,
    output logic        [16:0] o_humidity
);
    import thc_pkg::*;

    t_coef r_coef;
    t_fine fine;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMP_REF:         r_coef.temp_ref     <= i_cfg_data[15:0];
                CFG_TEMP_SLOPE:       r_coef.temp_slope   <= i_cfg_data[15:0];
                CFG_TEMP_CURVE:       r_coef.temp_curve   <= i_cfg_data[15:0];
                CFG_HUM_QUAD:         r_coef.hum_quad     <= i_cfg_data[7:0];
                CFG_HUM_GAIN:         r_coef.hum_gain     <= i_cfg_data[15:0];
                CFG_HUM_TEMP_LIN:     r_coef.hum_temp_lin <= i_cfg_data[7:0];
                CFG_HUM_OFFSET_SLOPE: begin
                    r_coef.hum_offset <= i_cfg_data[11:0];
                    r_coef.hum_slope  <= i_cfg_data[23:12];
                end
                CFG_HUM_TEMP_SQ:      r_coef.hum_temp_sq  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    thc_fine_temp u_fine_temp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coef     (r_coef),
        .i_valid    (start && !busy),
        .i_temp_adc (i_temp_adc),
        .i_hum_adc  (i_hum_adc),
        .o_fine     (fine)
    );

    thc_humidity u_humidity (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coef        (r_coef),
        .i_fine        (fine),
        .o_valid       (o_done),
        .o_temperature (o_temperature),
        .o_humidity    (o_humidity)
    );

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result without a sample transfer");

    a_hum_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_humidity <= HUM_CLAMP[28:12]))
        else $error("humidity above full scale");

    a_no_done_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_done)
        else $error("result right after reset");

endmodule
